/* hdl/okvt_pkg.sv */
package okvt_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int OP_W     = 3;
	localparam int POS_W    = 4;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KV_W     = KEY_W + VAL_W;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 3'd0,
		OP_UPDATE   = 3'd1,
		OP_UPSERT   = 3'd2,
		OP_ERASE    = 3'd3,
		OP_GET_KEY  = 3'd4,
		OP_GET_POS  = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SEARCH,
		ST_SHIFT_UP,
		ST_SHIFT_DN,
		ST_FETCH,
		ST_DONE
	} state_t;

endpackage

/* hdl/okvt_req_if.sv */
interface okvt_req_if;
	import okvt_pkg::*;

	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  opcode;
	logic [KEY_W-1:0] req_key;
	logic [VAL_W-1:0] req_value;
	logic [POS_W-1:0] position;

	modport source (output valid, opcode, req_key, req_value, position, input ready);
	modport sink   (input valid, opcode, req_key, req_value, position, output ready);
endinterface

/* hdl/okvt_rsp_if.sv */
interface okvt_rsp_if;
	import okvt_pkg::*;

	logic             valid;
	logic             ready;
	logic             success;
	logic [KEY_W-1:0] found_key;
	logic [VAL_W-1:0] found_value;
	logic [CNT_W-1:0] entry_count;
	logic             table_full;

	modport source (output valid, success, found_key, found_value, entry_count, table_full,
		input ready);
	modport sink   (input valid, success, found_key, found_value, entry_count, table_full,
		output ready);
endinterface

/* hdl/ordered_key_value_table_core.sv */
// Operation: a key search reads the entries in order from index 0 until a hit or the last entry;
// insert (and upsert of a new key) adds a shift pass that moves every entry up one, erase of a
// hit one that moves the entries above it down one; get_by_position reads the one entry.
// Throughput: one request at a time; the next transfer is taken the cycle after the result
// is loaded, so the scan and shift through the RAM's one read port (one entry read per cycle) set the rate.
// Reset: arst_n clears state machine, entry count and output valid; entry RAM is not cleared.
module ordered_key_value_table_core (
	input  logic clk,
	input  logic arst_n,
	okvt_req_if.sink   req,
	okvt_rsp_if.source rsp
);
	import okvt_pkg::*;

	// Sequencer state and latched request
	state_t           state_q, state_d;
	op_t              op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [POS_W-1:0] pos_q;

	// Table occupancy and walk counters
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] scan_q, scan_d;    // next entry to read during a search
	logic [IDX_W-1:0] ptr_q, ptr_d;      // next entry to read during a shift
	logic [CNT_W-1:0] left_q, left_d;    // shift reads still to issue

	// Result staged before it moves into the output register
	logic             res_ok_q, res_ok_d;
	logic [KEY_W-1:0] res_key_q, res_key_d;
	logic [VAL_W-1:0] res_val_q, res_val_d;
	logic             res_full_q, res_full_d;

	// RAM port controls; the read is tracked one stage behind
	logic             rd_en, wr_en;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	logic [KV_W-1:0]  wr_data, rd_data;
	logic             rd_valid_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [KEY_W-1:0] rd_key;
	logic [VAL_W-1:0] rd_val;
	logic             match, last_entry;

	// Output register
	logic             out_valid_q;
	logic             out_load;
	logic             out_ok_q;
	logic [KEY_W-1:0] out_key_q;
	logic [VAL_W-1:0] out_val_q;
	logic [CNT_W-1:0] out_count_q;
	logic             out_full_q;

	logic             req_xfer;

	// Keys and values live side by side in one RAM word: {key, value}
	okvt_ram #(
		.WIDTH (KV_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_key     = rd_data[KV_W-1:VAL_W];
	assign rd_val     = rd_data[VAL_W-1:0];
	assign match      = rd_valid_s1 && (rd_key == key_q);
	assign last_entry = (CNT_W'(rd_idx_s1) + CNT_W'(1)) == count_q;

	assign req.ready  = (state_q == ST_IDLE);
	assign req_xfer   = req.valid && req.ready;

	assign rsp.valid       = out_valid_q;
	assign rsp.success     = out_ok_q;
	assign rsp.found_key   = out_key_q;
	assign rsp.found_value = out_val_q;
	assign rsp.entry_count = out_count_q;
	assign rsp.table_full  = out_full_q;

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		scan_d     = scan_q;
		ptr_d      = ptr_q;
		left_d     = left_q;
		res_ok_d   = res_ok_q;
		res_key_d  = res_key_q;
		res_val_d  = res_val_q;
		res_full_d = res_full_q;
		rd_en      = 1'b0;
		rd_addr    = scan_q[IDX_W-1:0];
		wr_en      = 1'b0;
		wr_addr    = '0;
		wr_data    = {key_q, val_q};
		out_load   = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_DISPATCH;
				end
			end

			ST_DISPATCH: begin
				// default outcome is a failed request with zero payload
				res_ok_d   = 1'b0;
				res_key_d  = '0;
				res_val_d  = '0;
				res_full_d = 1'b0;
				scan_d     = '0;
				case (op_q)
					OP_GET_POS: begin
						if (CNT_W'(pos_q) < count_q) begin
							rd_en   = 1'b1;
							rd_addr = IDX_W'(pos_q);
							state_d = ST_FETCH;
						end else begin
							state_d = ST_DONE;
						end
					end
					OP_INSERT, OP_UPDATE, OP_UPSERT, OP_ERASE, OP_GET_KEY: begin
						state_d = ST_SEARCH;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end

			ST_SEARCH: begin
				if (match) begin
					case (op_q)
						OP_INSERT: begin
							// key already present: report stored entry, no change
							res_key_d = rd_key;
							res_val_d = rd_val;
							state_d   = ST_DONE;
						end
						OP_UPDATE, OP_UPSERT: begin
							wr_en     = 1'b1;
							wr_addr   = rd_idx_s1;
							res_ok_d  = 1'b1;
							res_key_d = key_q;
							res_val_d = val_q;
							state_d   = ST_DONE;
						end
						OP_GET_KEY: begin
							res_ok_d  = 1'b1;
							res_key_d = rd_key;
							res_val_d = rd_val;
							state_d   = ST_DONE;
						end
						OP_ERASE: begin
							// close the gap: entries above the hit move down one
							res_ok_d  = 1'b1;
							res_key_d = rd_key;
							res_val_d = rd_val;
							ptr_d     = rd_idx_s1 + IDX_W'(1);
							left_d    = count_q - CNT_W'(1) - CNT_W'(rd_idx_s1);
							state_d   = ST_SHIFT_DN;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end else if ((count_q == '0) || (rd_valid_s1 && last_entry)) begin
					case (op_q)
						OP_INSERT, OP_UPSERT: begin
							if (count_q == CNT_W'(CAPACITY)) begin
								res_full_d = 1'b1;
								state_d    = ST_DONE;
							end else begin
								// open slot 0: walk from the top entry down
								ptr_d   = IDX_W'(count_q - CNT_W'(1));
								left_d  = count_q;
								state_d = ST_SHIFT_UP;
							end
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end else if (scan_q < count_q) begin
					rd_en   = 1'b1;
					rd_addr = scan_q[IDX_W-1:0];
					scan_d  = scan_q + CNT_W'(1);
				end
			end

			ST_SHIFT_UP: begin
				if (rd_valid_s1) begin
					wr_en   = 1'b1;
					wr_addr = rd_idx_s1 + IDX_W'(1);
					wr_data = rd_data;
				end
				if (left_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = ptr_q;
					ptr_d   = ptr_q - IDX_W'(1);
					left_d  = left_q - CNT_W'(1);
				end else if (!rd_valid_s1) begin
					wr_en     = 1'b1;
					wr_addr   = '0;
					wr_data   = {key_q, val_q};
					count_d   = count_q + CNT_W'(1);
					res_ok_d  = 1'b1;
					res_key_d = key_q;
					res_val_d = val_q;
					state_d   = ST_DONE;
				end
			end

			ST_SHIFT_DN: begin
				if (rd_valid_s1) begin
					wr_en   = 1'b1;
					wr_addr = rd_idx_s1 - IDX_W'(1);
					wr_data = rd_data;
				end
				if (left_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = ptr_q;
					ptr_d   = ptr_q + IDX_W'(1);
					left_d  = left_q - CNT_W'(1);
				end else if (!rd_valid_s1) begin
					count_d = count_q - CNT_W'(1);
					state_d = ST_DONE;
				end
			end

			ST_FETCH: begin
				res_ok_d  = 1'b1;
				res_key_d = rd_key;
				res_val_d = rd_val;
				state_d   = ST_DONE;
			end

			ST_DONE: begin
				// hand the result over once the output register is free
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rd_valid_s1 <= rd_en;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_q  <= op_t'(req.opcode);
			key_q <= req.req_key;
			val_q <= req.req_value;
			pos_q <= req.position;
		end
		scan_q     <= scan_d;
		ptr_q      <= ptr_d;
		left_q     <= left_d;
		res_ok_q   <= res_ok_d;
		res_key_q  <= res_key_d;
		res_val_q  <= res_val_d;
		res_full_q <= res_full_d;
		rd_idx_s1  <= rd_addr;
		if (out_load) begin
			out_ok_q    <= res_ok_q;
			out_key_q   <= res_key_q;
			out_val_q   <= res_val_q;
			out_count_q <= count_q;
			out_full_q  <= res_full_q;
		end
	end

	// Occupancy never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// A full-table failure is never reported as a success
	a_full_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !(res_full_q && res_ok_q))
		else $error("full flag with success");

	// Shift passes never read and write the same entry in one cycle
	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("read and write collide on one entry");

	// Read data only returns in states that consume it
	a_rd_owner: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == ST_SEARCH || state_q == ST_SHIFT_UP ||
			state_q == ST_SHIFT_DN || state_q == ST_FETCH))
		else $error("read data returned outside a consuming state");

	// Count only moves by one, and only on completion of a request
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (state_q == ST_DONE))
		else $error("count changed outside completion");
endmodule

/* hdl/okvt_ram.sv */
module okvt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

/* dv/ordered_key_value_table_core_test.sv */
module ordered_key_value_table_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import okvt_pkg::*;

	// Opcodes 6 and 7 are unused by the block: they must act as no-ops.
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	localparam int RANDOM_ITEMS  = 2000;
	localparam int KEY_POOL_SIZE = 22;    // a few more keys than entries, so the table fills
	localparam int BIAS_STRETCH  = 40;    // requests per fill or drain stretch
	localparam int HOLD_EVERY    = 300;   // sender waits for an empty pipeline this often
	localparam int SETTLE_CYCLES = 60;    // wait after the last result, before judging
	localparam int STALL_LIMIT   = 3000;  // cycles without any transfer before giving up
	localparam int PRINT_LIMIT   = 200;

	// Idle percentages per traffic phase: sender light / receiver heavy, then swapped,
	// then no idling at all.
	localparam int SEND_IDLE_PH0 = 34;
	localparam int SEND_IDLE_PH1 = 85;
	localparam int RECV_IDLE_PH0 = 85;
	localparam int RECV_IDLE_PH1 = 34;

	typedef struct {
		logic [OP_W-1:0]  opcode;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic [POS_W-1:0] position;
		int               phase;
		bit               hold;   // wait until every outstanding result is back
	} table_request_t;

	typedef struct {
		logic             success;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] count;
		logic             full;
	} table_result_t;

	logic clk;
	logic arst_n;

	okvt_req_if req_bus();
	okvt_rsp_if rsp_bus();

	ordered_key_value_table_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	table_request_t   pending_requests[$];
	table_result_t    predicted_results[$];
	table_request_t   on_bus;
	int               traffic_phase;
	int               mismatch_count;
	int               results_seen;
	int               quiet_cycles;

	// Shadow of the table contents, in list order (index 0 is newest).
	logic [KEY_W-1:0] shadow_keys[CAPACITY];
	logic [VAL_W-1:0] shadow_values[CAPACITY];
	int               shadow_count;

	logic [KEY_W-1:0] key_pool[KEY_POOL_SIZE];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Applies one request to the shadow table and returns the result it must produce.
	// Key search takes the first match in list order; failed operations leave state alone.
	function automatic table_result_t apply_table_op(table_request_t r);
		table_result_t res;
		int            hit;
		res = '{default: '0};
		hit = shadow_count;
		for (int i = shadow_count - 1; i >= 0; i--) begin
			if (shadow_keys[i] == r.key)
				hit = i;
		end
		case (r.opcode)
			OP_INSERT, OP_UPDATE, OP_UPSERT: begin
				if (hit < shadow_count) begin
					if (r.opcode == OP_INSERT) begin
						// present key: insert refuses, reports the stored pair
						res.key   = shadow_keys[hit];
						res.value = shadow_values[hit];
					end else begin
						shadow_values[hit] = r.value;
						res.success = 1'b1;
						res.key     = r.key;
						res.value   = r.value;
					end
				end else if (r.opcode != OP_UPDATE) begin
					if (shadow_count < CAPACITY) begin
						for (int i = shadow_count; i > 0; i--) begin
							shadow_keys[i]   = shadow_keys[i-1];
							shadow_values[i] = shadow_values[i-1];
						end
						shadow_keys[0]   = r.key;
						shadow_values[0] = r.value;
						shadow_count++;
						res.success = 1'b1;
						res.key     = r.key;
						res.value   = r.value;
					end else begin
						res.full = 1'b1;
					end
				end
			end
			OP_ERASE: begin
				if (hit < shadow_count) begin
					res.success = 1'b1;
					res.key     = shadow_keys[hit];
					res.value   = shadow_values[hit];
					for (int i = hit; i + 1 < shadow_count; i++) begin
						shadow_keys[i]   = shadow_keys[i+1];
						shadow_values[i] = shadow_values[i+1];
					end
					shadow_count--;
				end
			end
			OP_GET_KEY: begin
				if (hit < shadow_count) begin
					res.success = 1'b1;
					res.key     = shadow_keys[hit];
					res.value   = shadow_values[hit];
				end
			end
			OP_GET_POS: begin
				if (int'(r.position) < shadow_count) begin
					res.success = 1'b1;
					res.key     = shadow_keys[r.position];
					res.value   = shadow_values[r.position];
				end
			end
			default: begin
			end
		endcase
		res.count = CNT_W'(shadow_count);
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("[%0t] result %0d: %s", $realtime, results_seen, msg);
		mismatch_count++;
	endtask

	task automatic check_result();
		table_result_t want;
		if (predicted_results.size() == 0) begin
			report_mismatch("result with no outstanding request");
		end else begin
			want = predicted_results.pop_front();
			if (rsp_bus.success !== want.success)
				report_mismatch($sformatf("success %0b, expected %0b",
					rsp_bus.success, want.success));
			if (rsp_bus.found_key !== want.key)
				report_mismatch($sformatf("found_key %h, expected %h",
					rsp_bus.found_key, want.key));
			if (rsp_bus.found_value !== want.value)
				report_mismatch($sformatf("found_value %h, expected %h",
					rsp_bus.found_value, want.value));
			if (rsp_bus.entry_count !== want.count)
				report_mismatch($sformatf("entry_count %0d, expected %0d",
					rsp_bus.entry_count, want.count));
			if (rsp_bus.table_full !== want.full)
				report_mismatch($sformatf("table_full %0b, expected %0b",
					rsp_bus.table_full, want.full));
		end
		results_seen++;
	endtask

	// Request driver. On a transfer the request is run through the shadow table and its
	// result queued. A new request goes out only when the slot is free, so valid never
	// drops while a request is waiting on ready.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
		end else begin
			if (req_bus.valid && req_bus.ready)
				predicted_results.push_back(apply_table_op(on_bus));
			if (!req_bus.valid || req_bus.ready) begin
				if (pending_requests.size() != 0
					&& !(pending_requests[0].hold && predicted_results.size() != 0)
					&& $urandom_range(99) >= ((pending_requests[0].phase == 0) ? SEND_IDLE_PH0 :
						(pending_requests[0].phase == 1) ? SEND_IDLE_PH1 : 0)) begin
					on_bus = pending_requests.pop_front();
					traffic_phase = on_bus.phase;
					req_bus.opcode    <= on_bus.opcode;
					req_bus.req_key   <= on_bus.key;
					req_bus.req_value <= on_bus.value;
					req_bus.position  <= on_bus.position;
					req_bus.valid     <= 1'b1;
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor; ready toggles at random per phase.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready)
				check_result();
			rsp_bus.ready <= $urandom_range(99) >= ((traffic_phase == 0) ? RECV_IDLE_PH0 :
				(traffic_phase == 1) ? RECV_IDLE_PH1 : 0);
		end
	end

	// Watchdog: any transfer on either channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		table_request_t r;
		int             roll;
		bit             filling;

		// known levels on every block input from time zero
		arst_n            = 1'b0;
		req_bus.valid     = 1'b0;
		req_bus.opcode    = OP_INSERT;
		req_bus.req_key   = '0;
		req_bus.req_value = '0;
		req_bus.position  = '0;
		rsp_bus.ready     = 1'b0;
		traffic_phase     = 0;
		mismatch_count    = 0;
		results_seen      = 0;
		shadow_count      = 0;

		// Key pool: both extremes plus random keys, so every key bit toggles and hits
		// are frequent enough to drive the table to full and back to empty.
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < KEY_POOL_SIZE; i++)
			key_pool[i] = $urandom;

		// Directed part: empty-table misses, field extremes, duplicate insert,
		// update through insert_or_update, reads past the count, erase at front,
		// middle and end, and the unused opcodes.
		r = '{opcode: OP_GET_POS, key: '0, value: '0, position: '0, phase: 0, hold: 1'b0};
		pending_requests.push_back(r);
		r.opcode = OP_GET_KEY;                                    pending_requests.push_back(r);
		r.opcode = OP_UPDATE;                                     pending_requests.push_back(r);
		r.opcode = OP_ERASE;                                      pending_requests.push_back(r);
		r.opcode = OP_INSERT; r.key = '0; r.value = '1;           pending_requests.push_back(r);
		r.opcode = OP_INSERT; r.key = '1; r.value = '0;           pending_requests.push_back(r);
		r.opcode = OP_INSERT; r.key = '0; r.value = 32'h1234_5678; pending_requests.push_back(r);
		r.opcode = OP_UPSERT; r.key = '1; r.value = 32'ha5a5_a5a5; pending_requests.push_back(r);
		r.opcode = OP_UPSERT; r.key = 32'h1234_5678; r.value = '0; pending_requests.push_back(r);
		r.opcode = OP_UPDATE; r.key = '0; r.value = 32'h5a5a_5a5a; pending_requests.push_back(r);
		r.opcode = OP_GET_KEY; r.key = '1;                        pending_requests.push_back(r);
		r.opcode = OP_GET_POS; r.position = 4'd0;                 pending_requests.push_back(r);
		r.position = 4'd2;                                        pending_requests.push_back(r);
		r.position = 4'd3;                                        pending_requests.push_back(r);
		r.position = '1;                                          pending_requests.push_back(r);
		r.opcode = OP_ERASE; r.key = '1;                          pending_requests.push_back(r);
		r.opcode = OP_GET_POS; r.position = 4'd1;                 pending_requests.push_back(r);
		r.opcode = OP_SPARE_LO; r.key = '1; r.value = '1;         pending_requests.push_back(r);
		r.opcode = OP_SPARE_HI;                                   pending_requests.push_back(r);
		r.opcode = OP_ERASE; r.key = 32'h1234_5678;               pending_requests.push_back(r);
		r.opcode = OP_ERASE; r.key = '0;                          pending_requests.push_back(r);
		r.opcode = OP_ERASE;                                      pending_requests.push_back(r);

		// Random part: alternating fill and drain stretches over a small key pool.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			filling = ((i / BIAS_STRETCH) % 2) == 0;
			roll = $urandom_range(99);
			if (filling) begin
				if (roll < 30)      r.opcode = OP_INSERT;
				else if (roll < 55) r.opcode = OP_UPSERT;
				else if (roll < 65) r.opcode = OP_UPDATE;
				else if (roll < 73) r.opcode = OP_ERASE;
				else if (roll < 85) r.opcode = OP_GET_KEY;
				else if (roll < 97) r.opcode = OP_GET_POS;
				else if (roll < 99) r.opcode = OP_SPARE_LO;
				else                r.opcode = OP_SPARE_HI;
			end else begin
				if (roll < 10)      r.opcode = OP_INSERT;
				else if (roll < 18) r.opcode = OP_UPSERT;
				else if (roll < 28) r.opcode = OP_UPDATE;
				else if (roll < 68) r.opcode = OP_ERASE;
				else if (roll < 83) r.opcode = OP_GET_KEY;
				else if (roll < 97) r.opcode = OP_GET_POS;
				else if (roll < 99) r.opcode = OP_SPARE_LO;
				else                r.opcode = OP_SPARE_HI;
			end
			r.key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL_SIZE-1)]
				: KEY_W'($urandom);
			roll = $urandom_range(9);
			r.value = (roll == 0) ? '0 : (roll == 1) ? '1 : VAL_W'($urandom);
			r.position = POS_W'($urandom_range(15));
			r.phase = (i * 3) / RANDOM_ITEMS;
			// pause the sender at each phase change and now and then in between
			r.hold = (i % HOLD_EVERY) == 0 || (i * 3) % RANDOM_ITEMS < 3;
			pending_requests.push_back(r);
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (pending_requests.size() != 0 || req_bus.valid || predicted_results.size() != 0);
		// let any stray result show up before judging
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
